// File: design/fvu_pkg.sv
// fvu_pkg: shared types and constants of the fluctuation velocity unit
// no dependencies; imported by the interfaces and every module

package fvu_pkg;

	localparam int FIELD_W = 32;  // port width of every vector component
	localparam int ENTRY_W = 20;  // signed Q4.16 gradient and spin entry
	localparam int FRAC_W = 16;   // fraction bits of Q16.16 and Q4.16
	localparam int DT_W = 32;     // unsigned Q0.32 time step
	// dt/2 * vel in Q16.16: drop 32 fraction bits of dt plus one for the halving
	localparam int DT_HALF_SHIFT = DT_W + 1;
	localparam int REG_W = 60;    // widest configuration register
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_MODE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TIME_STEP = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GRAD_ROW0 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_GRAD_ROW1 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_GRAD_ROW2 = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SPIN = 3'd5;

	typedef enum logic [2:0] {
		MODE_NONE = 3'd0,
		MODE_POSITION = 3'd1,
		MODE_VELOCITY = 3'd2,
		MODE_VELOCITY2 = 3'd3,
		MODE_MIDSTEP = 3'd4
	} deform_mode_t;

	// load enables of the four pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

// File: design/fvu_if.sv
// fvu_in_if / fvu_out_if: valid-ready channels of the fluctuation velocity unit
// depends on fvu_pkg for the field width

interface fvu_in_if import fvu_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [FIELD_W-1:0] pos_x;
	logic signed [FIELD_W-1:0] pos_y;
	logic signed [FIELD_W-1:0] pos_z;
	logic signed [FIELD_W-1:0] vel_x;
	logic signed [FIELD_W-1:0] vel_y;
	logic signed [FIELD_W-1:0] vel_z;
	logic signed [FIELD_W-1:0] angvel_x;
	logic signed [FIELD_W-1:0] angvel_y;
	logic signed [FIELD_W-1:0] angvel_z;

	modport source (
		output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		angvel_x, angvel_y, angvel_z,
		input ready
	);
	modport sink (
		input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		angvel_x, angvel_y, angvel_z,
		output ready
	);
endinterface

interface fvu_out_if import fvu_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [FIELD_W-1:0] fluct_vel_x;
	logic signed [FIELD_W-1:0] fluct_vel_y;
	logic signed [FIELD_W-1:0] fluct_vel_z;
	logic signed [FIELD_W-1:0] fluct_ang_x;
	logic signed [FIELD_W-1:0] fluct_ang_y;
	logic signed [FIELD_W-1:0] fluct_ang_z;

	modport source (
		output valid, fluct_vel_x, fluct_vel_y, fluct_vel_z,
		fluct_ang_x, fluct_ang_y, fluct_ang_z,
		input ready
	);
	modport sink (
		input valid, fluct_vel_x, fluct_vel_y, fluct_vel_z,
		fluct_ang_x, fluct_ang_y, fluct_ang_z,
		output ready
	);
endinterface

// File: design/fvu_lane.sv
// fvu_lane: one vector component, stages 1 and 2 (spin removal, midstep offset)
// depends on fvu_pkg

module fvu_lane import fvu_pkg::*; #(
	parameter int VEC_W = 32
) (
	input  logic                      clk,
	input  stage_en_t                 en,
	input  logic                      mid,
	input  logic [DT_W-1:0]           time_step,
	input  logic signed [VEC_W-1:0]   pos,
	input  logic signed [VEC_W-1:0]   vel,
	input  logic signed [VEC_W-1:0]   ang,
	input  logic signed [ENTRY_W-1:0] spin,
	output logic signed [VEC_W:0]     d,
	output logic signed [VEC_W-1:0]   vel_o,
	output logic signed [VEC_W-1:0]   fa
);

	localparam int PW = VEC_W + DT_W + 1;
	localparam int AW = ((VEC_W > ENTRY_W) ? VEC_W : ENTRY_W) + 1;

	logic signed [AW-1:0] ang_diff;
	logic signed [VEC_W-1:0] ang_sat;
	logic signed [PW-1:0] prod_s1;
	logic signed [VEC_W-1:0] pos_s1, vel_s1, fa_s1;
	logic mid_s1;
	logic signed [VEC_W-1:0] half_off;
	logic signed [VEC_W:0] d_mid;
	logic signed [VEC_W:0] d_s2;
	logic signed [VEC_W-1:0] vel_s2, fa_s2;

	always_comb begin
		ang_diff = AW'(ang) - AW'(spin);
		if (&ang_diff[AW-1:VEC_W-1] || ~|ang_diff[AW-1:VEC_W-1]) begin
			ang_sat = ang_diff[VEC_W-1:0];
		end else if (ang_diff[AW-1]) begin
			ang_sat = {1'b1, {(VEC_W-1){1'b0}}};
		end else begin
			ang_sat = {1'b0, {(VEC_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_s1 <= $signed({1'b0, time_step}) * vel;
			pos_s1 <= pos;
			vel_s1 <= vel;
			mid_s1 <= mid;
			fa_s1 <= mid ? ang_sat : ang;
		end
	end

	// floor of dt*vel / 2^33 is the top VEC_W bits of the product
	assign half_off = $signed(prod_s1[PW-1:DT_HALF_SHIFT]);
	assign d_mid = (VEC_W+1)'(pos_s1) - (VEC_W+1)'(half_off);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			d_s2 <= mid_s1 ? d_mid : (VEC_W+1)'(pos_s1);
			vel_s2 <= vel_s1;
			fa_s2 <= fa_s1;
		end
	end

	assign d = d_s2;
	assign vel_o = vel_s2;
	assign fa = fa_s2;

endmodule

// File: design/fvu_row.sv
// fvu_row: one gradient row, stages 3 and 4; merges the three lane offsets
// depends on fvu_pkg

module fvu_row import fvu_pkg::*; #(
	parameter int VEC_W = 32
) (
	input  logic                      clk,
	input  stage_en_t                 en,
	input  logic                      grad,
	input  logic signed [ENTRY_W-1:0] g [3],
	input  logic signed [VEC_W:0]     d [3],
	input  logic signed [VEC_W-1:0]   vel,
	output logic signed [VEC_W-1:0]   fv
);

	localparam int DW = VEC_W + 1;
	localparam int PW = DW + ENTRY_W;
	localparam int SW = PW + 2;
	localparam int TW = SW + 1;

	logic signed [PW-1:0] p_s3 [3];
	logic signed [VEC_W-1:0] vel_s3;
	logic grad_s3;
	logic signed [SW-1:0] sum;
	logic signed [TW-1:0] diff, shifted;
	logic signed [VEC_W-1:0] fv_sat;
	logic signed [VEC_W-1:0] fv_s4;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int k = 0; k < 3; k++) begin
				p_s3[k] <= g[k] * d[k];
			end
			vel_s3 <= vel;
			grad_s3 <= grad;
		end
	end

	always_comb begin
		sum = SW'(p_s3[0]) + SW'(p_s3[1]) + SW'(p_s3[2]);
		diff = (TW'(vel_s3) <<< FRAC_W) - TW'(sum);
		shifted = diff >>> FRAC_W;
		if (&shifted[TW-1:VEC_W-1] || ~|shifted[TW-1:VEC_W-1]) begin
			fv_sat = shifted[VEC_W-1:0];
		end else if (shifted[TW-1]) begin
			fv_sat = {1'b1, {(VEC_W-1){1'b0}}};
		end else begin
			fv_sat = {1'b0, {(VEC_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			fv_s4 <= grad_s3 ? fv_sat : vel_s3;
		end
	end

	assign fv = fv_s4;

endmodule

// File: design/fluctuation_velocity_unit_top.sv
// fluctuation_velocity_unit_top: configuration registers, stage control, lanes and rows
// depends on fvu_pkg, fvu_if, fvu_lane and fvu_row

// Takes one particle word per cycle while din.ready is high. The fluctuating velocity and
// angular velocity of a word are offered on the output from the last of four register
// stages, the first loaded at acceptance. Each stage has its own valid bit, so a word
// is accepted whenever any stage downstream can move; a stalled output only holds
// the block once all four stages are full. Stage 1 forms dt*vel in three lanes (one
// per component) and removes the spin, stage 2 the midstep offset, stage 3 the nine
// gradient products in three rows, stage 4 the row sums and saturation; spin removal
// and the midstep offset apply in midstep mode only.
// Configuration must be written while the pipeline is empty; there is no
// clearing pass.

module fluctuation_velocity_unit_top import fvu_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_en,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	fvu_in_if.sink               din,
	fvu_out_if.source            dout
);

	localparam int VEC_W = (COORD_WIDTH > FIELD_W) ? FIELD_W : COORD_WIDTH;

	logic [2:0] mode_q;
	logic [DT_W-1:0] time_step_q;
	logic [REG_W-1:0] grad_row_q [3];
	logic [REG_W-1:0] spin_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	stage_en_t en;

	logic mid, grad;
	logic grad_s1, grad_s2;

	logic signed [VEC_W-1:0] pos_in [3];
	logic signed [VEC_W-1:0] vel_in [3];
	logic signed [VEC_W-1:0] ang_in [3];
	logic signed [ENTRY_W-1:0] spin_ent [3];
	logic signed [ENTRY_W-1:0] g_ent [3][3];

	logic signed [VEC_W:0] lane_d [3];
	logic signed [VEC_W-1:0] lane_vel [3];
	logic signed [VEC_W-1:0] lane_fa [3];
	logic signed [VEC_W-1:0] fa_s3 [3];
	logic signed [VEC_W-1:0] fa_s4 [3];
	logic signed [VEC_W-1:0] row_fv [3];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			time_step_q <= '0;
			grad_row_q[0] <= '0;
			grad_row_q[1] <= '0;
			grad_row_q[2] <= '0;
			spin_q <= '0;
		end else if (cfg_en) begin
			case (cfg_index)
				REG_MODE: mode_q <= cfg_data[2:0];
				REG_TIME_STEP: time_step_q <= cfg_data[DT_W-1:0];
				REG_GRAD_ROW0: grad_row_q[0] <= cfg_data;
				REG_GRAD_ROW1: grad_row_q[1] <= cfg_data;
				REG_GRAD_ROW2: grad_row_q[2] <= cfg_data;
				REG_SPIN: spin_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// unused mode codes fall through to pass-through
	assign mid = (mode_q == MODE_MIDSTEP);
	assign grad = mode_q inside {MODE_VELOCITY, MODE_VELOCITY2, MODE_MIDSTEP};

	// per-stage ready: a stage loads when empty or when its word moves on
	assign rdy4 = !valid_s4 || dout.ready;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;
	assign en = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4};
	assign din.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= din.valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) grad_s1 <= grad;
		if (en.s2) grad_s2 <= grad_s1;
	end

	// inputs are taken as signed VEC_W-bit values
	always_comb begin
		pos_in[0] = din.pos_x[VEC_W-1:0];
		pos_in[1] = din.pos_y[VEC_W-1:0];
		pos_in[2] = din.pos_z[VEC_W-1:0];
		vel_in[0] = din.vel_x[VEC_W-1:0];
		vel_in[1] = din.vel_y[VEC_W-1:0];
		vel_in[2] = din.vel_z[VEC_W-1:0];
		ang_in[0] = din.angvel_x[VEC_W-1:0];
		ang_in[1] = din.angvel_y[VEC_W-1:0];
		ang_in[2] = din.angvel_z[VEC_W-1:0];
		for (int i = 0; i < 3; i++) begin
			spin_ent[i] = $signed(spin_q[ENTRY_W*i +: ENTRY_W]);
			for (int k = 0; k < 3; k++) begin
				g_ent[i][k] = $signed(grad_row_q[i][ENTRY_W*k +: ENTRY_W]);
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		fvu_lane #(.VEC_W(VEC_W)) u_lane (
			.clk      (clk),
			.en       (en),
			.mid      (mid),
			.time_step(time_step_q),
			.pos      (pos_in[i]),
			.vel      (vel_in[i]),
			.ang      (ang_in[i]),
			.spin     (spin_ent[i]),
			.d        (lane_d[i]),
			.vel_o    (lane_vel[i]),
			.fa       (lane_fa[i])
		);
	end

	for (genvar i = 0; i < 3; i++) begin : g_row
		fvu_row #(.VEC_W(VEC_W)) u_row (
			.clk (clk),
			.en  (en),
			.grad(grad_s2),
			.g   (g_ent[i]),
			.d   (lane_d),
			.vel (lane_vel[i]),
			.fv  (row_fv[i])
		);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (en.s3) fa_s3[i] <= lane_fa[i];
			if (en.s4) fa_s4[i] <= fa_s3[i];
		end
	end

	assign dout.valid = valid_s4;
	assign dout.fluct_vel_x = FIELD_W'(row_fv[0]);
	assign dout.fluct_vel_y = FIELD_W'(row_fv[1]);
	assign dout.fluct_vel_z = FIELD_W'(row_fv[2]);
	assign dout.fluct_ang_x = FIELD_W'(fa_s4[0]);
	assign dout.fluct_ang_y = FIELD_W'(fa_s4[1]);
	assign dout.fluct_ang_z = FIELD_W'(fa_s4[2]);

	// an accepted word lands in stage 1
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		din.valid && din.ready |=> valid_s1)
		else $error("accepted word missing from stage 1");

	// input held off only when every stage is occupied
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!din.ready |-> valid_s1 && valid_s2 && valid_s3 && valid_s4)
		else $error("input stalled with a bubble in the pipeline");

	// a word in stage 3 is not dropped while the output stalls
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && !dout.ready && valid_s3 |=> valid_s3 && valid_s4)
		else $error("stage 3 word lost under output stall");

endmodule
